// ----- rtl/sha256_pkg.sv -----
// shared types, constants and round functions of the sha-256 stream hasher
`default_nettype none
package sha256_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;

  // kind codes of an input word
  localparam logic KindAbsorb = 1'b0;
  localparam logic KindFinish = 1'b1;

  // command handed from front to back
  typedef enum logic [1:0] {
    CmdAbsorb = 2'd0,
    CmdFinish = 2'd1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } cmd_t;

  // back engine state
  typedef enum logic [2:0] {
    StIdle   = 3'd0,
    StRound  = 3'd1,
    StUpdate = 3'd2,
    StPad    = 3'd3,
    StEmit   = 3'd4
  } state_e;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[idx];
  endfunction

  function automatic logic [31:0] initial_h(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[idx];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sha256_if.sv -----
// valid/ready stream interfaces for input and digest words
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/sha256_front.sv -----
// front end: classifies input words and queues commands for the engine
`default_nettype none
module sha256_front #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [7:0]        data_byte_i,
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output sha256_pkg::cmd_t       cmd_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha256_pkg::cmd_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;
  logic push, pop;
  sha256_pkg::cmd_t cmd_in;

  // classify the word
  always_comb begin
    cmd_in.data = data_byte_i;
    cmd_in.cmd  = (kind_i == sha256_pkg::KindFinish) ? sha256_pkg::CmdFinish
                                                      : sha256_pkg::CmdAbsorb;
  end

  assign in_ready_o  = (cnt_q != Depth[Aw:0]);
  assign cmd_valid_o = (cnt_q != '0);
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;
  assign cmd_o = mem_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cmd_in;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + {{Aw{1'b0}}, push} - {{Aw{1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/sha256_engine.sv -----
// back end: block buffer, one-round-per-cycle compression, padding, digest out
`default_nettype none
module sha256_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire sha256_pkg::cmd_t  cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            digest_word_o,
  output logic [2:0]             word_index_o,
  output logic                   last_word_o
);
  sha256_pkg::state_e state_q, state_d;

  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];     // message schedule window, also the block buffer
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic        fin_q;        // compression is part of a finish
  logic        second_q;     // a length-only block still follows
  logic [2:0]  oidx_q;
  logic        ovalid_q;

  logic take;
  logic [31:0] w_new, t1, t2, wt;
  logic [31:0] byte_word;
  logic [63:0] total;

  assign take = cmd_valid_i && cmd_ready_o;
  assign total = len_q + {55'd0, fill_q, 3'd0};

  // round datapath
  always_comb begin
    wt = w_q[0];
    w_new = (sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
             ^ (w_q[14] >> 10)) + w_q[9]
          + (sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3))
          + w_q[0];
    t1 = v_q[7] + (sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
         ^ sha256_pkg::rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + sha256_pkg::round_k(rnd_q) + wt;
    t2 = (sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
          ^ sha256_pkg::rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    byte_word = w_q[fill_q[5:2]];
    case (fill_q[1:0])
      2'd0:    byte_word[31:24] = cmd_i.data;
      2'd1:    byte_word[23:16] = cmd_i.data;
      2'd2:    byte_word[15:8]  = cmd_i.data;
      default: byte_word[7:0]   = cmd_i.data;
    endcase
  end

  // next state and handshake
  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    case (state_q)
      sha256_pkg::StIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          if (cmd_i.cmd == sha256_pkg::CmdFinish) state_d = sha256_pkg::StPad;
          else if (fill_q == 6'd63)               state_d = sha256_pkg::StRound;
        end
      end
      sha256_pkg::StPad:    state_d = sha256_pkg::StRound;
      sha256_pkg::StRound:  if (rnd_q == 6'd63) state_d = sha256_pkg::StUpdate;
      sha256_pkg::StUpdate: begin
        if (second_q)   state_d = sha256_pkg::StRound;
        else if (fin_q) state_d = sha256_pkg::StEmit;
        else            state_d = sha256_pkg::StIdle;
      end
      sha256_pkg::StEmit: if (ovalid_q && out_ready_i && oidx_q == 3'd7)
        state_d = sha256_pkg::StIdle;
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sha256_pkg::StIdle;
    else         state_q <= state_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::initial_h(3'(i));
      fill_q   <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      second_q <= 1'b0;
      oidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      case (state_q)
        sha256_pkg::StIdle: if (take) begin
          if (cmd_i.cmd == sha256_pkg::CmdFinish) begin
            fin_q <= 1'b1;
          end else begin
            fill_q <= fill_q + 1'b1;
            fin_q  <= 1'b0;
            if (fill_q == 6'd63) len_q <= len_q + 64'd512;
          end
          rnd_q <= '0;
        end
        sha256_pkg::StPad: begin
          second_q <= (fill_q >= 6'd56);
          rnd_q    <= '0;
        end
        sha256_pkg::StRound: rnd_q <= rnd_q + 1'b1;
        sha256_pkg::StUpdate: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          second_q <= 1'b0;
          if (!second_q && fin_q) begin
            ovalid_q <= 1'b1;
            oidx_q   <= '0;
          end
        end
        sha256_pkg::StEmit: if (ovalid_q && out_ready_i) begin
          oidx_q <= oidx_q + 1'b1;
          if (oidx_q == 3'd7) begin
            ovalid_q <= 1'b0;
            fin_q    <= 1'b0;
            fill_q   <= '0;
            len_q    <= '0;
            for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::initial_h(3'(i));
          end
        end
        default: ;
      endcase
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    case (state_q)
      sha256_pkg::StIdle: if (take) begin
        if (cmd_i.cmd == sha256_pkg::CmdAbsorb) w_q[fill_q[5:2]] <= byte_word;
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
      sha256_pkg::StPad: begin
        // 0x80 at fill position, zeros after, length if it fits
        for (int b = 0; b < 64; b++) begin
          if (6'(b) == fill_q)
            w_q[b/4][31-8*(b%4) -: 8] <= 8'h80;
          else if (6'(b) > fill_q && (b < 56 || fill_q >= 6'd56))
            w_q[b/4][31-8*(b%4) -: 8] <= 8'h00;
        end
        if (fill_q < 6'd56) begin
          w_q[14] <= total[63:32];
          w_q[15] <= total[31:0];
        end
      end
      sha256_pkg::StRound: begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
        v_q[0] <= t1 + t2;
        v_q[1] <= v_q[0];
        v_q[2] <= v_q[1];
        v_q[3] <= v_q[2];
        v_q[4] <= v_q[3] + t1;
        v_q[5] <= v_q[4];
        v_q[6] <= v_q[5];
        v_q[7] <= v_q[6];
      end
      sha256_pkg::StUpdate: begin
        if (second_q) begin
          for (int i = 0; i < 14; i++) w_q[i] <= '0;
          w_q[14] <= total[63:32];
          w_q[15] <= total[31:0];
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i] + v_q[i];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ovalid_q;
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);
endmodule
`default_nettype wire

// ----- rtl/sha256_stream_hasher_core.sv -----
// sha-256 stream hasher top level: front queue plus compression engine
// absorb word: taken while the engine is idle; the 64th byte of a block starts a compression that holds the engine
// finish word: padding, then the round and update states for one block or for two blocks, then 8 digest words
// throughput is set by the single round unit, one round per cycle
// the front queue keeps taking words while the engine compresses, until the queue is full
// rst_ni clears control state and loads the initial hash values
`default_nettype none
module sha256_stream_hasher_core #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sha256_in_if.sink     in_i,
  sha256_out_if.source  out_o
);
  logic             cmd_valid, cmd_ready;
  sha256_pkg::cmd_t cmd;

  sha256_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid), .in_ready_o (in_i.ready),
    .kind_i (in_i.kind), .data_byte_i (in_i.data_byte),
    .cmd_valid_o (cmd_valid), .cmd_ready_i (cmd_ready), .cmd_o (cmd)
  );

  sha256_engine u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid), .cmd_ready_o (cmd_ready), .cmd_i (cmd),
    .out_valid_o (out_o.valid), .out_ready_i (out_o.ready),
    .digest_word_o (out_o.digest_word), .word_index_o (out_o.word_index),
    .last_word_o (out_o.last_word)
  );
endmodule
`default_nettype wire

// ----- rtl/sha256_checker.sv -----
// port-level checker of the sha-256 hasher, bound to the top level
`default_nettype none
module sha256_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  word_index,
  input wire logic        last_word,
  input wire logic [31:0] digest_word
);
  // last flag marks word seven only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");

  // word index advances by one after each taken word but the last
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && word_index != 3'd7) |=>
      (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("word index did not advance");

  // a stalled digest word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word)))
    else $error("digest word changed while stalled");

  // a digest starts at word zero
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest did not start at word zero");
endmodule

bind sha256_stream_hasher_core sha256_checker u_checker (
  .clk_i, .rst_ni,
  .out_valid (out_o.valid), .out_ready (out_o.ready),
  .word_index (out_o.word_index), .last_word (out_o.last_word),
  .digest_word (out_o.digest_word)
);
`default_nettype wire

// ----- tb/sha256_stream_hasher_core_test.sv -----
// testbench for the sha-256 stream hasher: byte stimulus, digest prediction and checking
module sha256_stream_hasher_core_test;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_stream_hasher_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  int unsigned fill_level;
  logic [63:0] message_bits;

  digest_word_t digest_queue [$];
  int unsigned error_count = 0;
  int unsigned words_checked = 0;
  int unsigned messages_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  bit sink_stalls = 1'b1;

  localparam int unsigned WatchdogLimit = 20000;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64-round compression of the byte buffer into the hash state
  task automatic compress_bytes();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    logic [31:0] kconst [64];
    kconst = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + kconst[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic restart_message();
    hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill_level = 0;
    message_bits = '0;
  endtask

  // advance the predictor by one accepted word
  task automatic predict_digest(logic kind, logic [7:0] data);
    logic [63:0] total;
    digest_word_t dw;
    if (kind == sha256_pkg::KindAbsorb) begin
      block_bytes[fill_level] = data;
      fill_level++;
      if (fill_level == 64) begin
        compress_bytes();
        message_bits += 64'd512;
        fill_level = 0;
      end
    end else begin
      total = message_bits + 64'(fill_level * 8);
      block_bytes[fill_level] = 8'h80;
      for (int i = fill_level + 1; i < 64; i++) block_bytes[i] = 8'h00;
      if (fill_level >= 56) begin
        compress_bytes();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block_bytes[56+i] = total[63-8*i -: 8];
      compress_bytes();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.index = 3'(i);
        dw.last = (i == 7);
        digest_queue.push_back(dw);
      end
      restart_message();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  // send one word, with a random gap first; valid stays up after the handshake
  task automatic send_word(logic kind, logic [7:0] data, bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= kind;
    in_if.data_byte <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_digest(kind, data);
    if (kind == sha256_pkg::KindFinish) messages_sent++;
    else bytes_sent++;
  endtask

  task automatic send_message(int unsigned len, bit gaps = 1'b1);
    for (int i = 0; i < len; i++) send_word(sha256_pkg::KindAbsorb, 8'($urandom), gaps);
    send_word(sha256_pkg::KindFinish, 8'($urandom), gaps);
  endtask

  // stop sending and wait for every expected digest word
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_queue.size() != 0) @(posedge clk_i);
  endtask

  // sink side: random stalls and the result check
  always @(posedge clk_i) begin
    digest_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (digest_queue.size() == 0) begin
        report_mismatch("unexpected word", out_if.digest_word, '0);
      end else begin
        want = digest_queue.pop_front();
        words_checked++;
        if (out_if.digest_word !== want.word)
          report_mismatch("digest_word", out_if.digest_word, want.word);
        if (out_if.word_index !== want.index)
          report_mismatch("word_index", 32'(out_if.word_index), 32'(want.index));
        if (out_if.last_word !== want.last)
          report_mismatch("last_word", 32'(out_if.last_word), 32'(want.last));
      end
    end
    if (idle_cycles != 0) begin
      idle_cycles--;
      out_if.ready <= 1'b0;
    end else if (sink_stalls && out_if.valid && out_if.ready && $urandom_range(0, 2) == 0) begin
      idle_cycles = $urandom_range(0, 18);
      out_if.ready <= (idle_cycles == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", quiet);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(sha256_pkg::KindFinish, 8'hff);     // empty message
    send_word(sha256_pkg::KindAbsorb, 8'h00);
    send_word(sha256_pkg::KindAbsorb, 8'hff);
    send_word(sha256_pkg::KindFinish, 8'h00);
    send_message(55, 1'b0);                       // padding fits one block
    send_message(56, 1'b0);                       // padding needs a second block
  endtask

  task automatic test_block_edges();
    send_message(63);
    send_message(64);
    send_message(65);
  endtask

  task automatic test_drained_pause();
    send_message(3);
    wait_drained();
    sink_stalls = 1'b0;
    send_message(10, 1'b0);
    sink_stalls = 1'b1;
  endtask

  task automatic test_random_stream();
    int unsigned sent;
    sent = 0;
    while (sent < 150) begin
      automatic int unsigned len = ($urandom_range(0, 7) == 0) ?
          $urandom_range(50, 130) : $urandom_range(0, 12);
      send_message(len);
      sent += len + 1;
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = sha256_pkg::KindAbsorb;
    in_if.data_byte = '0;
    out_if.ready = 1'b0;
    restart_message();
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_block_edges();
    test_drained_pause();
    test_random_stream();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("covered %0d messages, %0d bytes, %0d digest words checked",
             messages_sent, bytes_sent, words_checked);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
